// ===== hw/rtl/bwd_pkg.sv =====
// Shared types, constants and header helpers for the bit-plane weight decompressor.
package bwd_pkg;

  localparam int BLOCK_WEIGHTS = 64;
  localparam int ROWS = 8;
  localparam int MAX_PLANES = 4;
  localparam int BURST_BEATS = 16;
  localparam logic [6:0] HEAD_NONE = 7'd64;

  typedef struct packed {
    logic [63:0] word_high;
    logic [63:0] word_low;
  } in_beat_t;

  typedef struct packed {
    logic signed [7:0] weight_0;
    logic signed [7:0] weight_1;
    logic signed [7:0] weight_2;
    logic signed [7:0] weight_3;
    logic signed [7:0] weight_4;
    logic signed [7:0] weight_5;
    logic signed [7:0] weight_6;
    logic signed [7:0] weight_7;
    logic        last_of_pair;
  } out_beat_t;

  // Head n sits at bits lo+1:lo, lo = 120 - 8*(n/4) + 2*(n%4).
  function automatic logic [1:0] head_at(input logic [127:0] w, input logic [5:0] n);
    logic [6:0] lo;
    lo = 7'd120 - {n[5:2], 3'b000} + {4'd0, n[1:0], 1'b0};
    return w[lo +: 2];
  endfunction

  function automatic logic [63:0] nonzero_heads(input logic [127:0] w);
    logic [63:0] m;
    for (int n = 0; n < BLOCK_WEIGHTS; n++) begin
      m[n] = |head_at(w, n[5:0]);
    end
    return m;
  endfunction

  // Index of the lowest set bit, HEAD_NONE if none.
  function automatic logic [6:0] first_set(input logic [63:0] m);
    logic [6:0] pos;
    pos = HEAD_NONE;
    for (int n = BLOCK_WEIGHTS - 1; n >= 0; n--) begin
      if (m[n]) pos = n[6:0];
    end
    return pos;
  endfunction

endpackage

// ===== hw/rtl/bitplane_weight_decompressor_top.sv =====
// Top level of the bit-plane weight decompressor.
// Takes one 128-bit beat per cycle: a header beat (64 two-bit heads) followed by
// head+1 plane beats for each block with a nonzero head; zero heads are skipped
// without taking beats. On the last plane of a block, eight decode lanes rebuild
// all 64 weights in the same cycle. The first block of a pair is held; when the
// second completes, the merge stage plays out 16 beats of eight weights (second
// block first, then the held one), last_of_pair high on the sixteenth. Input
// runs at one beat per cycle; it stalls only when a pair completes while the
// previous 16-beat burst is still draining, so the output port (16 beats per
// pair) sets the sustained rate. An unpaired final block stays held.
module bitplane_weight_decompressor_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bwd_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output bwd_pkg::out_beat_t out_beat
);
  import bwd_pkg::*;

  logic [127:0]          header;
  logic [6:0]            head_position;
  logic [1:0]            planes_received;
  logic [1:0]            current_head;
  logic                  pair_phase;
  logic [3:0][127:0]     plane_store;
  logic [7:0][63:0]      held_block;

  logic [127:0]          word;
  logic [3:0][127:0]     planes;
  logic [7:0][63:0]      rows;
  logic                  hdr_mode, fin, pair_done, acc, busy;
  logic [6:0]            seek_hdr, seek_next;

  assign word      = {in_beat.word_high, in_beat.word_low};
  assign hdr_mode  = head_position[6];
  assign fin       = !hdr_mode && (planes_received == current_head);
  assign pair_done = fin && pair_phase;
  // Hold input only when a pair would finish into a busy merge stage.
  assign in_stall  = pair_done && busy;
  assign acc       = in_valid && !in_stall;

  assign seek_hdr  = first_set(nonzero_heads(word));
  assign seek_next = first_set(nonzero_heads(header) &
                               ((~64'h0 << head_position[5:0]) << 1));

  // Current beat stands in for the plane still arriving.
  always_comb begin
    for (int p = 0; p < MAX_PLANES; p++) begin
      planes[p] = (p[1:0] == planes_received) ? word : plane_store[p];
    end
  end

  for (genvar r = 0; r < ROWS; r++) begin : g_lane
    bwd_lane #(.ROW(r)) u_lane (
      .planes (planes),
      .head   (current_head),
      .row    (rows[r])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header <= '0;
      head_position <= HEAD_NONE;
      planes_received <= '0;
      current_head <= '0;
      pair_phase <= 1'b0;
    end else if (acc) begin
      if (hdr_mode) begin
        header <= word;
        head_position <= seek_hdr;
        planes_received <= '0;
        current_head <= seek_hdr[6] ? 2'd0 : head_at(word, seek_hdr[5:0]);
      end else if (!fin) begin
        planes_received <= planes_received + 2'd1;
      end else begin
        head_position <= seek_next;
        planes_received <= '0;
        current_head <= seek_next[6] ? 2'd0 : head_at(header, seek_next[5:0]);
        pair_phase <= !pair_phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !hdr_mode) plane_store[planes_received] <= word;
    if (acc && fin && !pair_phase) held_block <= rows;
  end

  bwd_burst u_burst (
    .clk       (clk),
    .rst       (rst),
    .load      (acc && pair_done),
    .new_rows  (rows),
    .old_rows  (held_block),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule

// ===== hw/rtl/bwd_lane.sv =====
// One decode lane: rebuilds the eight weights of one row from the bit planes.
module bwd_lane #(
  parameter int ROW = 0
) (
  input  logic [3:0][127:0] planes,
  input  logic [1:0]        head,
  output logic [63:0]       row
);
  import bwd_pkg::*;

  always_comb begin
    logic [7:0] v;
    logic [6:0] lo;
    row = '0;
    for (int j = 0; j < 8; j++) begin
      // weight k = 8*ROW + j takes bits 127-2k:126-2k of each plane
      lo = 7'(126 - 2 * (8 * ROW + j));
      v = {planes[3][lo +: 2], planes[2][lo +: 2], planes[1][lo +: 2], planes[0][lo +: 2]};
      unique case (head)
        2'd1:    row[8*j +: 8] = {{4{v[3]}}, v[3:0]};
        2'd2:    row[8*j +: 8] = {{2{v[5]}}, v[5:0]};
        2'd3:    row[8*j +: 8] = v;
        default: row[8*j +: 8] = '0;
      endcase
    end
  end

endmodule

// ===== hw/rtl/bwd_burst.sv =====
// Merge stage: holds a decoded block pair and plays it out as sixteen beats.
module bwd_burst (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [7:0][63:0]    new_rows,
  input  logic [7:0][63:0]    old_rows,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_stall,
  output bwd_pkg::out_beat_t  out_beat
);
  import bwd_pkg::*;

  logic [7:0][63:0] second_rows;
  logic [7:0][63:0] first_rows;
  logic [3:0]       cnt;
  logic             active;
  logic             last_go;
  logic [63:0]      cur;

  // Last beat of the burst leaves this cycle; a new pair may load behind it.
  assign last_go = active && !out_stall && (cnt == 4'(BURST_BEATS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt <= '0;
    end else if (load) begin
      active <= 1'b1;
      cnt <= '0;
    end else if (active && !out_stall) begin
      if (last_go) active <= 1'b0;
      cnt <= cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      second_rows <= new_rows;
      first_rows <= old_rows;
    end
  end

  assign cur = cnt[3] ? first_rows[cnt[2:0]] : second_rows[cnt[2:0]];
  assign busy = active && !last_go;
  assign out_valid = active;

  always_comb begin
    out_beat.weight_0 = cur[7:0];
    out_beat.weight_1 = cur[15:8];
    out_beat.weight_2 = cur[23:16];
    out_beat.weight_3 = cur[31:24];
    out_beat.weight_4 = cur[39:32];
    out_beat.weight_5 = cur[47:40];
    out_beat.weight_6 = cur[55:48];
    out_beat.weight_7 = cur[63:56];
    out_beat.last_of_pair = (cnt == 4'(BURST_BEATS - 1));
  end

endmodule

// ===== hw/rtl/bwd_checker.sv =====
// Port-level checks for the bit-plane weight decompressor, bound to the top level.
module bwd_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input bwd_pkg::in_beat_t  in_beat,
  input logic               out_valid,
  input logic               out_stall,
  input bwd_pkg::out_beat_t out_beat
);

  // Input holds only while a burst is draining.
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid) else $error("input stalled with no burst");

  // A stalled input beat holds.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_beat))
    else $error("stalled input beat changed");

  // The beat after a last beat is never another last beat.
  a_last_spacing: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_beat.last_of_pair |=>
    !(out_valid && out_beat.last_of_pair))
    else $error("last beat repeated right after last beat");

  // A stalled beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("stalled output beat changed");

endmodule

bind bitplane_weight_decompressor_top bwd_checker u_bwd_checker (.*);

// ===== tb/bitplane_weight_decompressor_top_tb.sv =====
// Testbench for the bit-plane weight decompressor top level.
module bitplane_weight_decompressor_top_tb;
  import bwd_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_beat;

  bitplane_weight_decompressor_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
    .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat)
  );

  // Predictor state: a shadow copy of the decoder's bookkeeping.
  logic [127:0] hdr_word;
  int unsigned  head_idx;
  int unsigned  planes_seen;
  int unsigned  blk_head;
  logic [127:0] planes [MAX_PLANES];
  logic [7:0]   held_wts [BLOCK_WEIGHTS];
  bit           holding_first;

  out_beat_t weight_rows_q [$];

  int unsigned mismatches = 0;
  int unsigned beats_sent;
  int unsigned beats_seen = 0;
  int unsigned bursts_seen = 0;
  int unsigned cycles = 0;
  bit          stall_mode;
  int unsigned stall_keep;
  int unsigned burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Head n: byte n/4 of the header, bits 2(n%4)+1:2(n%4); byte 0 at the top.
  function automatic int unsigned hdr_head(logic [127:0] w, int unsigned n);
    logic [7:0] b;
    b = w[127 - 8 * (n / 4) -: 8];
    return 32'((b >> (2 * (n % 4))) & 8'h03);
  endfunction

  function automatic void skip_zero_heads(int unsigned start);
    int unsigned n;
    n = start;
    while (n < BLOCK_WEIGHTS && hdr_head(hdr_word, n) == 0) n++;
    head_idx = n;
    planes_seen = 0;
    blk_head = (n < BLOCK_WEIGHTS) ? hdr_head(hdr_word, n) : 0;
  endfunction

  // Rebuild weight k from its two-bit slices, plane 0 least significant.
  function automatic logic [7:0] decode_weight(int unsigned k);
    logic [7:0]  v;
    logic [7:0]  b;
    int unsigned wid;
    v = '0;
    for (int p = 0; p <= blk_head; p++) begin
      b = planes[p][127 - 8 * (k / 4) -: 8];
      v |= ((b >> (6 - 2 * (k % 4))) & 8'h03) << (2 * p);
    end
    wid = 2 * (blk_head + 1);
    if (wid < 8 && v[wid - 1]) v |= 8'hFF << wid;
    return v;
  endfunction

  function automatic void push_block(logic [7:0] w [BLOCK_WEIGHTS], bit last_blk);
    out_beat_t r;
    for (int row = 0; row < ROWS; row++) begin
      r.weight_0 = w[8 * row + 0];
      r.weight_1 = w[8 * row + 1];
      r.weight_2 = w[8 * row + 2];
      r.weight_3 = w[8 * row + 3];
      r.weight_4 = w[8 * row + 4];
      r.weight_5 = w[8 * row + 5];
      r.weight_6 = w[8 * row + 6];
      r.weight_7 = w[8 * row + 7];
      r.last_of_pair = last_blk && row == ROWS - 1;
      weight_rows_q.push_back(r);
    end
  endfunction

  // Advance the predictor by one accepted beat and queue any weight rows.
  function automatic void predict_word(logic [127:0] w);
    logic [7:0] cur [BLOCK_WEIGHTS];
    if (head_idx >= BLOCK_WEIGHTS) begin
      hdr_word = w;
      skip_zero_heads(0);
      return;
    end
    planes[planes_seen] = w;
    if (planes_seen < blk_head) begin
      planes_seen++;
      return;
    end
    for (int k = 0; k < BLOCK_WEIGHTS; k++) cur[k] = decode_weight(k);
    skip_zero_heads(head_idx + 1);
    if (!holding_first) begin
      held_wts = cur;
      holding_first = 1'b1;
    end else begin
      push_block(cur, 1'b0);
      push_block(held_wts, 1'b1);
      holding_first = 1'b0;
    end
  endfunction

  // Send one beat: hold it until accepted; gaps come between bursts.
  task automatic send_word(logic [127:0] w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_beat <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(w);
    beats_sent++;
    burst_left--;
  endtask

  task automatic idle_until_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (weight_rows_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [127:0] make_header(int unsigned fill);
    logic [127:0] h;
    for (int n = 0; n < BLOCK_WEIGHTS; n++)
      h[127 - 8 * (n / 4) - 7 + 2 * (n % 4) +: 2] = (fill == 4) ? 2'($urandom) : 2'(fill);
    return h;
  endfunction

  function automatic logic [127:0] rand_word();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Walk a header: send one header then the planes each nonzero head needs.
  task automatic send_header_set(logic [127:0] h, int unsigned pat);
    send_word(h);
    for (int n = 0; n < BLOCK_WEIGHTS; n++) begin
      for (int p = 0; p < hdr_head(h, n) + (hdr_head(h, n) != 0); p++) begin
        case (pat)
          0: send_word('0);
          1: send_word('1);
          default: send_word(rand_word());
        endcase
      end
    end
  endtask

  // Heads at the extremes: all-zero headers, then four max heads fed all-ones, zero, patterned and random planes.
  task automatic test_extreme_heads();
    send_word(make_header(0));
    send_word(make_header(0));
    send_word(make_header(3) & {{120{1'b0}}, 8'hFF});
    repeat (4) send_word('1);
    repeat (4) send_word('0);
    repeat (4) send_word(128'h0123_4567_89AB_CDEF_FEDC_BA98_7654_3210);
    repeat (4) send_word(rand_word());
    idle_until_drained();
  endtask

  // Each head value once, pairs across headers, plus an odd block left held.
  task automatic test_each_head();
    logic [127:0] h;
    for (int v = 1; v <= 3; v++) begin
      h = '0;
      h[127 - 8 * 15 - 7 +: 2] = 2'(v);
      send_word(h);
      repeat (v + 1) send_word(rand_word());
    end
    idle_until_drained();
  endtask

  task automatic test_random_headers();
    logic [127:0] h;
    int unsigned  items;
    items = 0;
    while (items < 300) begin
      case ($urandom_range(0, 9))
        0: h = rand_word();
        1: h = make_header(0);
        default: begin
          // Sparse headers set at most six nonzero heads, so each header set stays short.
          h = '0;
          repeat ($urandom_range(1, 6))
            h[$urandom_range(0, 63) * 2 +: 2] = 2'($urandom_range(1, 3));
        end
      endcase
      send_header_set(h, $urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : 2);
      items = beats_sent;
      if ($urandom_range(0, 7) == 0) idle_until_drained();
    end
    idle_until_drained();
  endtask

  // Receiver stall pattern: randomly chosen runs of always-ready and of random stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_keep = 0;
    end else begin
      if (stall_keep == 0) begin
        stall_mode = $urandom_range(0, 2) != 0;
        stall_keep = $urandom_range(5, 60);
      end
      stall_keep--;
      out_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
    end
  end

  // Compare every accepted output beat with the oldest expected row.
  always @(posedge clk) begin
    out_beat_t exp_row;
    if (!rst && out_valid && !out_stall) begin
      beats_seen++;
      if (out_beat.last_of_pair) bursts_seen++;
      if (weight_rows_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", out_beat);
      end else begin
        exp_row = weight_rows_q[0];
        weight_rows_q.delete(0);
        if (out_beat !== exp_row) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h got %h", exp_row, out_beat);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("timeout with %0d rows pending", weight_rows_q.size());
      $display("bitplane_weight_decompressor_top_tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_beat = '0;
    beats_sent = 0;
    burst_left = 0;
    hdr_word = '0;
    head_idx = BLOCK_WEIGHTS;
    planes_seen = 0;
    blk_head = 0;
    holding_first = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extreme_heads();
    test_each_head();
    test_random_headers();
    in_valid <= 1'b0;
    repeat (40) @(posedge clk);
    $display("sent %0d words, checked %0d weight rows in %0d pair bursts",
             beats_sent, beats_seen, bursts_seen);
    if (mismatches == 0 && weight_rows_q.size() == 0)
      $display("bitplane_weight_decompressor_top_tb: done, clean");
    else
      $display("bitplane_weight_decompressor_top_tb: done, errors");
    $finish;
  end

endmodule
